>>> rtl/cvg_pkg.sv
// Shared types and constants for the circle vertex generator.
// Holds the request and vertex word layouts and the fixed-point constants.
// Depends on nothing; used by rtl/circle_vertex_generator.sv.
package cvg_pkg;

  // Q7.16 coordinate limits.
  localparam int COORD_W = 24;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7F_FFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh80_0000;

  // Q2.30 constants of the sine/cosine series.
  localparam logic [30:0] ONE_Q30     = 31'd1073741824;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] ROUND_Q16   = 31'd8192;

  // Number of series terms, and width of the signed term accumulators.
  localparam int TERMS = 7;
  localparam int ACC_W = 34;

  // Quadrant codes of the phase (top two bits of a full turn).
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // Request word.
  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic [6:0]                segment_count;
  } req_t;

  // Vertex word.
  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic signed [COORD_W-1:0] vertex_z;
    logic                      last_vertex;
  } vtx_t;

  // Data that rides along the sine/cosine pipeline next to the arithmetic.
  typedef struct packed {
    logic [1:0]                quad;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic                      last;
  } side_t;

endpackage

>>> rtl/circle_vertex_generator.sv
// Circle vertex generator: a request word (centre and segment count n) becomes n vertex
// words spaced evenly around the unit circle about the centre, the last one flagged.
// A count of zero gives no vertex and a count above MAX_SEGMENTS is clipped to it. The
// request port takes one word and then stalls while the phase sequencer issues one vertex
// per cycle while the vertex port does not stall, until the last vertex has been issued.
// Each vertex then passes an 18-stage sine/cosine pipeline (phase scaling, angle squaring,
// six multiply/divide pairs of the Taylor series, sum, rounding, quadrant and saturating
// add) and leaves it at one vertex word per cycle. A stall on the vertex port freezes
// the whole pipeline. There is no memory and no clearing pass.
// Depends on rtl/cvg_pkg.sv.
module circle_vertex_generator #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  cvg_pkg::req_t req,
  output logic          vtx_valid,
  input  logic          vtx_stall,
  output cvg_pkg::vtx_t vtx
);

  localparam int NW    = $clog2(MAX_SEGMENTS + 1);
  localparam int RW    = $clog2(MAX_SEGMENTS);
  localparam int NK    = cvg_pkg::TERMS - 1;
  localparam int ACW   = cvg_pkg::ACC_W;
  localparam int ST_F1 = 3 + 2 * NK;
  localparam int ST_F2 = ST_F1 + 1;
  localparam int ST_O  = ST_F2 + 1;

  // Phase step tables: floor(2^24 / n) and 2^24 mod n for every count.
  wire [23:0]   step_tbl [0:MAX_SEGMENTS];
  wire [RW-1:0] rem_tbl  [0:MAX_SEGMENTS];

  for (genvar g = 0; g <= MAX_SEGMENTS; g++) begin : g_step
    localparam int SegN = (g == 0) ? 1 : g;
    localparam int StepV = (1 << 24) / SegN;
    localparam int RemV = (1 << 24) % SegN;
    assign step_tbl[g] = (g == 0) ? 24'd0 : StepV[23:0];
    assign rem_tbl[g]  = RW'(RemV);
  end

  // Sequencer registers.
  logic          busy;
  cvg_pkg::req_t req_r;
  logic [NW-1:0] n_reg;
  logic [NW-1:0] i_cnt;
  logic [23:0]   p_acc;
  logic [23:0]   step;
  logic [RW-1:0] racc;
  logic [RW-1:0] rem;

  logic          adv;
  logic          req_acc;
  logic          issue;
  logic [NW-1:0] nsat;
  logic [RW:0]   sum_r;
  logic          wrap;
  logic [RW-1:0] racc_next;
  logic [23:0]   p_next;
  logic          last_i;

  // Pipeline registers.
  logic [ST_O:0]  vld;
  cvg_pkg::side_t side_r [0:ST_F2];
  logic [21:0]    r0;
  logic [30:0]    t1;
  logic [30:0]    a_r    [0:NK];
  logic [30:0]    b_r    [0:NK];
  logic [31:0]    t2_r   [0:NK];
  logic signed [ACW-1:0] sacc_r [0:NK];
  logic signed [ACW-1:0] cacc_r [0:NK];
  logic [31:0]    pa_r   [NK];
  logic [31:0]    pb_r   [NK];
  logic [31:0]    t2m_r  [NK];
  logic signed [ACW-1:0] saccm_r [NK];
  logic signed [ACW-1:0] caccm_r [NK];
  logic signed [ACW-1:0] s_sum;
  logic signed [ACW-1:0] c_sum;
  logic [16:0]    s_q16;
  logic [16:0]    c_q16;
  cvg_pkg::vtx_t  vtx_r;

  // Stage results.
  logic [52:0] t_prod;
  logic [61:0] t2_prod;
  wire  [31:0] pa_w [NK];
  wire  [31:0] pb_w [NK];
  wire  signed [ACW-1:0] sm_w [NK];
  wire  signed [ACW-1:0] cm_w [NK];
  wire  [30:0] qa_w [NK];
  wire  [30:0] qb_w [NK];
  logic signed [ACW-1:0] s_fin;
  logic signed [ACW-1:0] c_fin;
  logic [16:0] s_rnd;
  logic [16:0] c_rnd;
  logic signed [17:0] cos_v;
  logic signed [17:0] sin_v;
  logic signed [24:0] x_sum;
  logic signed [24:0] y_sum;
  cvg_pkg::vtx_t vtx_next;

  // Clamp a series sum to [0, 1.0] and round Q2.30 to Q16.
  function automatic logic [16:0] round_q16(input logic signed [ACW-1:0] v);
    logic [30:0] c;
    logic [30:0] s;
    if (v < 0) begin
      c = '0;
    end else if (v > ACW'(cvg_pkg::ONE_Q30)) begin
      c = cvg_pkg::ONE_Q30;
    end else begin
      c = v[30:0];
    end
    s = c + cvg_pkg::ROUND_Q16;
    return s[30:14];
  endfunction

  // Saturate a 25-bit sum to the Q7.16 coordinate range.
  function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
    if (v > 25'(cvg_pkg::COORD_MAX)) begin
      return cvg_pkg::COORD_MAX;
    end else if (v < 25'(cvg_pkg::COORD_MIN)) begin
      return cvg_pkg::COORD_MIN;
    end else begin
      return v[23:0];
    end
  endfunction

  // Handshake: the whole pipe moves unless a finished vertex is held.
  assign adv       = !(vld[ST_O] && vtx_stall);
  assign req_stall = busy;
  assign req_acc   = req_valid && !busy;
  assign issue     = busy && adv;
  assign vtx_valid = vld[ST_O];
  assign vtx       = vtx_r;

  // Count clipping and the exact phase step with remainder carry.
  always_comb begin
    if (int'(req.segment_count) > MAX_SEGMENTS) begin
      nsat = NW'(MAX_SEGMENTS);
    end else begin
      nsat = req.segment_count[NW-1:0];
    end
    sum_r     = {1'b0, racc} + {1'b0, rem};
    wrap      = sum_r >= (RW+1)'(n_reg);
    racc_next = wrap ? RW'(sum_r - (RW+1)'(n_reg)) : sum_r[RW-1:0];
    p_next    = p_acc + step + {23'd0, wrap};
    last_i    = (i_cnt == n_reg - NW'(1));
  end

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req_acc) begin
      busy <= (nsat != '0);
    end else if (issue && last_i) begin
      busy <= 1'b0;
    end
  end

  // Sequencer payload: load on a request, step the phase on each issue.
  always_ff @(posedge clk) begin
    if (req_acc) begin
      req_r <= req;
      n_reg <= nsat;
      i_cnt <= '0;
      p_acc <= '0;
      racc  <= '0;
      step  <= step_tbl[nsat];
      rem   <= rem_tbl[nsat];
    end else if (issue) begin
      i_cnt <= i_cnt + NW'(1);
      p_acc <= p_next;
      racc  <= racc_next;
    end
  end

  // Angle scaling and squaring.
  assign t_prod  = {31'd0, r0} * {22'd0, cvg_pkg::HALF_PI_Q30};
  assign t2_prod = {31'd0, t1} * {31'd0, t1};

  // Series term stages: multiply by t^2, then divide by the factorial step.
  for (genvar k = 0; k < NK; k++) begin : g_term
    localparam int DivA = (2 * k + 2) * (2 * k + 3);
    localparam int DivB = (2 * k + 1) * (2 * k + 2);
    localparam int ShA = 32 + $clog2(DivA);
    localparam int ShB = 32 + $clog2(DivB);
    localparam logic [63:0] MulA = ((64'd1 << ShA) + 64'(DivA) - 64'd1) / 64'(DivA);
    localparam logic [63:0] MulB = ((64'd1 << ShB) + 64'(DivB) - 64'd1) / 64'(DivB);
    localparam bit Neg = (k % 2) == 1;

    logic [62:0] prod_a;
    logic [62:0] prod_b;
    logic [71:0] quo_a;
    logic [71:0] quo_b;
    logic signed [ACW-1:0] a_ext;
    logic signed [ACW-1:0] b_ext;

    assign prod_a = {32'd0, a_r[k]} * {31'd0, t2_r[k]};
    assign prod_b = {32'd0, b_r[k]} * {31'd0, t2_r[k]};
    assign pa_w[k] = prod_a[61:30];
    assign pb_w[k] = prod_b[61:30];

    // Terms alternate in sign, starting with an added term.
    assign a_ext = $signed({{(ACW-31){1'b0}}, a_r[k]});
    assign b_ext = $signed({{(ACW-31){1'b0}}, b_r[k]});
    assign sm_w[k] = Neg ? sacc_r[k] - a_ext : sacc_r[k] + a_ext;
    assign cm_w[k] = Neg ? cacc_r[k] - b_ext : cacc_r[k] + b_ext;

    // Exact floor division by a constant through a reciprocal multiply.
    assign quo_a = {40'd0, pa_r[k]} * {39'd0, MulA[32:0]};
    assign quo_b = {40'd0, pb_r[k]} * {39'd0, MulB[32:0]};
    assign qa_w[k] = quo_a[ShA +: 31];
    assign qb_w[k] = quo_b[ShB +: 31];
  end

  // Last term, rounding, quadrant mapping and the saturating add.
  always_comb begin
    if ((NK % 2) == 1) begin
      s_fin = sacc_r[NK] - $signed({{(ACW-31){1'b0}}, a_r[NK]});
      c_fin = cacc_r[NK] - $signed({{(ACW-31){1'b0}}, b_r[NK]});
    end else begin
      s_fin = sacc_r[NK] + $signed({{(ACW-31){1'b0}}, a_r[NK]});
      c_fin = cacc_r[NK] + $signed({{(ACW-31){1'b0}}, b_r[NK]});
    end
    s_rnd = round_q16(s_sum);
    c_rnd = round_q16(c_sum);
    case (side_r[ST_F2].quad)
      cvg_pkg::QUAD_0: begin
        cos_v = $signed({1'b0, c_q16});
        sin_v = $signed({1'b0, s_q16});
      end
      cvg_pkg::QUAD_1: begin
        cos_v = -$signed({1'b0, s_q16});
        sin_v = $signed({1'b0, c_q16});
      end
      cvg_pkg::QUAD_2: begin
        cos_v = -$signed({1'b0, c_q16});
        sin_v = -$signed({1'b0, s_q16});
      end
      default: begin
        cos_v = $signed({1'b0, s_q16});
        sin_v = -$signed({1'b0, c_q16});
      end
    endcase
    x_sum = 25'(side_r[ST_F2].cx) + 25'(cos_v);
    y_sum = 25'(side_r[ST_F2].cy) + 25'(sin_v);
    vtx_next.vertex_x    = sat24(x_sum);
    vtx_next.vertex_y    = sat24(y_sum);
    vtx_next.vertex_z    = side_r[ST_F2].cz;
    vtx_next.last_vertex = side_r[ST_F2].last;
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[ST_O-1:0], busy};
    end
  end

  // Pipeline payload registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0].quad <= p_acc[23:22];
      side_r[0].cx   <= req_r.center_x;
      side_r[0].cy   <= req_r.center_y;
      side_r[0].cz   <= req_r.center_z;
      side_r[0].last <= last_i;
      for (int s = 1; s <= ST_F2; s++) begin
        side_r[s] <= side_r[s-1];
      end
      r0        <= p_acc[21:0];
      t1        <= t_prod[52:22];
      a_r[0]    <= t1;
      b_r[0]    <= cvg_pkg::ONE_Q30;
      sacc_r[0] <= '0;
      cacc_r[0] <= '0;
      for (int k = 0; k < NK; k++) begin
        pa_r[k]     <= pa_w[k];
        pb_r[k]     <= pb_w[k];
        t2m_r[k]    <= t2_r[k];
        saccm_r[k]  <= sm_w[k];
        caccm_r[k]  <= cm_w[k];
        a_r[k+1]    <= qa_w[k];
        b_r[k+1]    <= qb_w[k];
        t2_r[k+1]   <= t2m_r[k];
        sacc_r[k+1] <= saccm_r[k];
        cacc_r[k+1] <= caccm_r[k];
      end
      s_sum <= s_fin;
      c_sum <= c_fin;
      s_q16 <= s_rnd;
      c_q16 <= c_rnd;
      vtx_r <= vtx_next;
    end
  end

  // Angle squared sits next to the angle entering the first term stage.
  always_ff @(posedge clk) begin
    if (adv) begin
      t2_r[0] <= t2_prod[61:30];
    end
  end

  // A request with a nonzero count always starts the sequencer.
  a_req_starts: assert property (@(posedge clk) disable iff (rst)
    req_acc && (nsat != '0) |=> busy)
    else $error("request with vertices did not start the sequencer");

  // The remainder accumulator stays below the count.
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> ((RW+1)'(racc) < (RW+1)'(n_reg)))
    else $error("phase remainder reached the segment count");

  // The vertex index stays below the count.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (i_cnt < n_reg))
    else $error("vertex index reached the segment count");

  // Issuing the last vertex ends the request.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    issue && last_i |=> !busy)
    else $error("sequencer stayed busy after the last vertex");

endmodule

>>> tb/circle_vertex_generator_test.sv
// Self-checking testbench for circle_vertex_generator: random and corner-case requests,
// vertex words predicted in-bench and compared in order. Random idling on both ports.
// Depends on rtl/cvg_pkg.sv and rtl/circle_vertex_generator.sv.
`timescale 1ns / 100ps

module circle_vertex_generator_test;

  typedef longint unsigned u64_t;

  localparam int SEG_LIMIT = 64;
  localparam int HOLD_CYCLES = 400;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_stall;
  cvg_pkg::req_t  req = '0;
  logic           vtx_valid;
  logic           vtx_stall = 1'b0;
  cvg_pkg::vtx_t  vtx;

  cvg_pkg::req_t request_queue[$];
  cvg_pkg::vtx_t vertex_queue[$];
  int unsigned mismatch_count = 0;
  int unsigned words_sent = 0;
  int unsigned words_total = 0;
  int unsigned cycle_count = 0;
  logic        req_taken = 1'b0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned holds_done = 0;

  circle_vertex_generator #(.MAX_SEGMENTS(SEG_LIMIT)) DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .vtx_valid(vtx_valid),
    .vtx_stall(vtx_stall),
    .vtx(vtx)
  );

  always #1 clk = ~clk;

  // Clamp a Q2.30 series sum to [0, 1] and round it to Q16.
  function automatic longint series_to_q16(input longint v);
    if (v < 0) v = 0;
    if (v > longint'(cvg_pkg::ONE_Q30)) v = longint'(cvg_pkg::ONE_Q30);
    return longint'((u64_t'(v) + u64_t'(cvg_pkg::ROUND_Q16)) >> 14);
  endfunction

  // Cosine and sine of the angle idx/n of a full turn, in Q16.
  function automatic void unit_circle_point(input int unsigned idx, input int unsigned n,
                                            output longint cos_q16, output longint sin_q16);
    u64_t phase, frac, t, t2, a, b;
    longint s, c;
    logic [1:0] quad;
    phase = ((u64_t'(idx) << 24) / u64_t'(n)) & 64'hFF_FFFF;
    quad = phase[23:22];
    frac = phase & 64'h3F_FFFF;
    t = (frac * u64_t'(cvg_pkg::HALF_PI_Q30)) >> 22;
    t2 = (t * t) >> 30;
    a = t;
    b = u64_t'(cvg_pkg::ONE_Q30);
    s = 0;
    c = 0;
    // Taylor series with alternating signs; each term comes from the previous one.
    for (int k = 0; k < cvg_pkg::TERMS; k++) begin
      if (k % 2 == 1) begin
        s -= longint'(a);
        c -= longint'(b);
      end else begin
        s += longint'(a);
        c += longint'(b);
      end
      a = ((a * t2) >> 30) / u64_t'((2 * k + 2) * (2 * k + 3));
      b = ((b * t2) >> 30) / u64_t'((2 * k + 1) * (2 * k + 2));
    end
    s = series_to_q16(s);
    c = series_to_q16(c);
    // Fold the first-quadrant result out to the quadrant of the phase.
    case (quad)
      cvg_pkg::QUAD_0: begin cos_q16 = c;  sin_q16 = s;  end
      cvg_pkg::QUAD_1: begin cos_q16 = -s; sin_q16 = c;  end
      cvg_pkg::QUAD_2: begin cos_q16 = -c; sin_q16 = -s; end
      default: begin cos_q16 = s; sin_q16 = -c; end
    endcase
  endfunction

  function automatic longint saturate_coord(input longint v);
    if (v > longint'(cvg_pkg::COORD_MAX)) return longint'(cvg_pkg::COORD_MAX);
    if (v < longint'(cvg_pkg::COORD_MIN)) return longint'(cvg_pkg::COORD_MIN);
    return v;
  endfunction

  // Queue every vertex word that one request must produce.
  task automatic queue_circle_vertices(input cvg_pkg::req_t r);
    int unsigned n;
    longint cv, sv;
    cvg_pkg::vtx_t v;
    n = 32'(r.segment_count);
    if (n > SEG_LIMIT) n = SEG_LIMIT;
    for (int unsigned i = 0; i < n; i++) begin
      unit_circle_point(i, n, cv, sv);
      v.vertex_x = 24'(saturate_coord(longint'($signed(r.center_x)) + cv));
      v.vertex_y = 24'(saturate_coord(longint'($signed(r.center_y)) + sv));
      v.vertex_z = r.center_z;
      v.last_vertex = (i + 1 == n);
      vertex_queue.insert(vertex_queue.size(), v);
    end
  endtask

  // Idle length: mostly none or short, now and then long; no idling in calm stretches.
  function automatic int unsigned idle_length(input int unsigned lane);
    int unsigned pick;
    if ((cycle_count / 600) % 3 == lane) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Coordinates lean toward the range ends so that the sums saturate often.
  function automatic logic signed [cvg_pkg::COORD_W-1:0] random_coord();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) return cvg_pkg::COORD_MAX - 24'($urandom_range(0, 32'h3_0000));
    if (pick < 24) return cvg_pkg::COORD_MIN + 24'($urandom_range(0, 32'h3_0000));
    return 24'($urandom());
  endfunction

  function automatic cvg_pkg::req_t random_request();
    cvg_pkg::req_t r;
    int unsigned pick;
    r.center_x = random_coord();
    r.center_y = random_coord();
    r.center_z = random_coord();
    pick = $urandom_range(0, 99);
    if (pick < 8) r.segment_count = 7'd0;
    else if (pick < 70) r.segment_count = 7'($urandom_range(1, 16));
    else if (pick < 88) r.segment_count = 7'($urandom_range(17, 48));
    else if (pick < 96) r.segment_count = 7'($urandom_range(49, 64));
    else r.segment_count = 7'($urandom_range(65, 127));
    return r;
  endfunction

  task automatic add_request(input logic signed [cvg_pkg::COORD_W-1:0] cx,
                             input logic signed [cvg_pkg::COORD_W-1:0] cy,
                             input logic signed [cvg_pkg::COORD_W-1:0] cz,
                             input int unsigned n);
    cvg_pkg::req_t r;
    r.center_x = cx;
    r.center_y = cy;
    r.center_z = cz;
    r.segment_count = 7'(n);
    request_queue.insert(request_queue.size(), r);
  endtask

  function automatic void check_field(input string name, input longint expected_value,
                                      input longint actual_value);
    if (expected_value != actual_value) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expected_value,
               actual_value);
      mismatch_count++;
    end
  endfunction

  // Request driver: offers the next word once the current one has been taken.
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        req_valid <= 1'b0;
      end else if (request_queue.size() > 0) begin
        req <= request_queue.pop_front();
        req_valid <= 1'b1;
        send_gap = idle_length(0);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Vertex port stall: random runs, plus two long hold-offs that back up the block.
  always @(negedge clk) begin
    if (rst) begin
      vtx_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      vtx_stall <= 1'b1;
    end else if (holds_done < 2 && words_sent >= (holds_done == 0 ? 40 : 250)) begin
      holds_done++;
      hold_left = HOLD_CYCLES - 1;
      vtx_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      vtx_stall <= 1'b1;
    end else begin
      stall_left = idle_length(1);
      vtx_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Monitor: predicts on each accepted request and checks each accepted vertex word.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    req_taken <= !rst && req_valid && !req_stall;
    if (!rst && req_valid && !req_stall) begin
      queue_circle_vertices(req);
      words_sent <= words_sent + 1;
    end
    if (!rst && vtx_valid && !vtx_stall) begin
      if (vertex_queue.size() == 0) begin
        $display("%0t: unexpected vertex word, got x %0d y %0d z %0d last %0d", $time,
                 vtx.vertex_x, vtx.vertex_y, vtx.vertex_z, vtx.last_vertex);
        mismatch_count++;
      end else begin
        cvg_pkg::vtx_t exp_word;
        exp_word = vertex_queue.pop_front();
        check_field("vertex_x", exp_word.vertex_x, vtx.vertex_x);
        check_field("vertex_y", exp_word.vertex_y, vtx.vertex_y);
        check_field("vertex_z", exp_word.vertex_z, vtx.vertex_z);
        check_field("last_vertex", exp_word.last_vertex, vtx.last_vertex);
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    // Counts: zero, single point, opposite pair, small polygons, limit and above.
    add_request(0, 0, 0, 0);
    add_request(0, 0, 0, 1);
    add_request(0, 0, 0, 2);
    add_request(0, 0, 0, 3);
    add_request(0, 0, 0, 4);
    add_request(24'sh01_0000, -24'sh02_0000, 24'sh00_8000, 8);
    // Centres at the range ends, so x and y saturate in both directions.
    add_request(cvg_pkg::COORD_MAX, cvg_pkg::COORD_MAX, cvg_pkg::COORD_MAX, 8);
    add_request(cvg_pkg::COORD_MIN, cvg_pkg::COORD_MIN, cvg_pkg::COORD_MIN, 8);
    add_request(cvg_pkg::COORD_MAX, cvg_pkg::COORD_MIN, 0, 4);
    add_request(cvg_pkg::COORD_MIN, cvg_pkg::COORD_MAX, -1, 6);
    add_request(cvg_pkg::COORD_MAX - 24'sh8000, cvg_pkg::COORD_MIN + 24'sh8000,
                24'sh55_5555, 12);
    add_request(24'sh01_2345, -24'sh02_3456, 24'sh7A_BCDE, 63);
    add_request(-24'sh12_3456, 24'sh0F_EDCB, -24'sh2A_AAAA, 64);
    add_request(24'sh00_0001, -24'sh00_0001, 24'sh00_0001, 65);
    add_request(-1, -1, -1, 127);
    add_request(24'sh3C_0000, -24'sh3C_0000, 24'sh10_0000, 100);
    add_request(1, 1, 1, 7);
    add_request(0, 0, cvg_pkg::COORD_MIN, 5);
    for (int k = 0; k < 392; k++) request_queue.insert(request_queue.size(), random_request());
    words_total = request_queue.size();

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    while (words_sent < words_total) @(posedge clk);
    while (vertex_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Timeout.
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> circle_vertex_generator.f
rtl/cvg_pkg.sv
rtl/circle_vertex_generator.sv
tb/circle_vertex_generator_test.sv
